>>> sv/ssa_pkg.sv
// constants and codes for the spring stiffness assembler
// no dependencies
package ssa_pkg;

    localparam int NODES     = 16;
    localparam int NODE_W    = 4;
    localparam int CNT_W     = 5;
    localparam int KEY_W     = 32;
    localparam int AE_W      = 24;
    localparam int FRAC_BITS = 16;
    localparam int LEN_FRAC  = 14;
    localparam int NUM_W     = AE_W + FRAC_BITS + LEN_FRAC;
    localparam int RAD_W     = 62;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int ENTRY_W   = 48;
    localparam int ITER_W    = 6;
    localparam int IN_W      = 80;
    localparam int OUT_W     = 64;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
    localparam logic [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};
    localparam logic [AE_W-1:0]    AE_RESET  = 24'd70000;

    localparam logic [1:0] ACT_ADD     = 2'd0;
    localparam logic [1:0] ACT_CONNECT = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_ZERO    = 3'd4;
    localparam logic [2:0] ST_SAT     = 3'd5;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_NRD  = 14'b00000000000010,
        S_NCMP = 14'b00000000000100,
        S_LRD  = 14'b00000000001000,
        S_LCMP = 14'b00000000010000,
        S_SQA  = 14'b00000000100000,
        S_SQB  = 14'b00000001000000,
        S_SQRT = 14'b00000010000000,
        S_DIV  = 14'b00000100000000,
        S_URD  = 14'b00001000000000,
        S_UWR  = 14'b00010000000000,
        S_MRA  = 14'b00100000000000,
        S_MRD  = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } state_t;

endpackage

>>> sv/spring_stiffness_assembler.sv
// spring stiffness assembler: node table, link table and global stiffness matrix
// depends on ssa_pkg
// add node scans the node table; read entry reads one matrix entry; connect scans
// the node and link tables, then runs a 31-step square root, a 54-step divider
// and four read-modify-writes
// one transaction is worked on at a time; the next is taken while a result waits
// reset (async, active low) empties both tables and clears the matrix valid bits
module spring_stiffness_assembler #(
    parameter int MAX_LINKS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ssa_pkg::AE_W-1:0]   cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // action, x_a, y_a, x_b, y_b, row_sel, col_sel
    input  logic [ssa_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status, node_slot, node_total, entry_value
    output logic [ssa_pkg::OUT_W-1:0]  m_axis_tdata
);
    import ssa_pkg::*;

    localparam int LC_W = $clog2(MAX_LINKS + 1);
    localparam int LI_W = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;

    logic [KEY_W-1:0]     node_mem [NODES];
    logic [2*NODE_W-1:0]  link_mem [MAX_LINKS];
    logic [ENTRY_W-1:0]   stiff_mem [NODES*NODES];
    logic [NODES*NODES-1:0] valid_reg;

    state_t               state_reg, state_next;
    logic [AE_W-1:0]      ae_reg;
    logic [CNT_W-1:0]     node_count_reg, node_count_next;
    logic [LC_W-1:0]      link_count_reg, link_count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [LC_W-1:0]      lidx_reg, lidx_next;
    logic                 pass_reg, pass_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [KEY_W-1:0]     key_b_reg, key_b_next;
    logic [1:0]           act_reg, act_next;
    logic [NODE_W-1:0]    row_reg, row_next, col_reg, col_next;
    logic [15:0]          adx_reg, adx_next, ady_reg, ady_next;
    logic [NODE_W-1:0]    ia_reg, ia_next, ib_reg, ib_next;
    logic                 fa_reg, fa_next;
    logic [KEY_W-1:0]     node_rd_reg;
    logic [2*NODE_W-1:0]  link_rd_reg;
    logic [ENTRY_W-1:0]   stiff_rd_reg;
    logic                 vrd_reg;
    logic [31:0]          sq_reg, sq_next;
    logic [RAD_W-1:0]     rad_reg, rad_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [NUM_W-1:0]     q_reg, q_next;
    logic [ROOT_W-1:0]    lq_reg, lq_next;
    logic [ENTRY_W-1:0]   k_reg, k_next;
    logic                 sat_reg, sat_next;
    logic [1:0]           upd_reg, upd_next;
    logic [2:0]           status_reg, status_next;
    logic [NODE_W-1:0]    slot_reg, slot_next;
    logic [ENTRY_W-1:0]   val_reg, val_next;
    logic                 ovalid_reg, ovalid_next;
    logic [2:0]           ostatus_reg, ostatus_next;
    logic [NODE_W-1:0]    oslot_reg, oslot_next;
    logic [CNT_W-1:0]     ototal_reg, ototal_next;
    logic [ENTRY_W-1:0]   oval_reg, oval_next;

    logic                 node_we, link_we, stiff_we;
    logic [2*NODE_W-1:0]  stiff_addr;
    logic [ENTRY_W-1:0]   stiff_wdata;
    logic [REM_W+1:0]     sq_trial_rem, sq_trial;
    logic [REM_W-1:0]     div_t;
    logic [ENTRY_W:0]     upd_sum;
    logic [ENTRY_W-1:0]   upd_cur;
    logic [16:0]          dx, dy;
    logic                 in_fire;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {4'b0, oval_reg, ototal_reg, oslot_reg, ostatus_reg};

    assign dx = {s_axis_tdata[17], s_axis_tdata[17:2]} - {s_axis_tdata[49], s_axis_tdata[49:34]};
    assign dy = {s_axis_tdata[33], s_axis_tdata[33:18]} - {s_axis_tdata[65], s_axis_tdata[65:50]};

    always_comb
    begin
        case (upd_reg)
            2'd0:    stiff_addr = {ia_reg, ia_reg};
            2'd1:    stiff_addr = {ib_reg, ib_reg};
            2'd2:    stiff_addr = {ia_reg, ib_reg};
            default: stiff_addr = {ib_reg, ia_reg};
        endcase
        if (state_reg == S_MRA)
        begin
            stiff_addr = {row_reg, col_reg};
        end
    end

    always_comb
    begin
        sq_trial_rem = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        sq_trial     = {2'b0, root_reg, 2'b01};
        div_t        = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
        upd_cur      = vrd_reg ? stiff_rd_reg : '0;
        if (upd_reg[1])
        begin
            upd_sum = {upd_cur[ENTRY_W-1], upd_cur} - {1'b0, k_reg};
        end
        else
        begin
            upd_sum = {upd_cur[ENTRY_W-1], upd_cur} + {1'b0, k_reg};
        end
        if (upd_sum[ENTRY_W] != upd_sum[ENTRY_W-1])
        begin
            stiff_wdata = upd_sum[ENTRY_W] ? ENTRY_MIN : ENTRY_MAX;
        end
        else
        begin
            stiff_wdata = upd_sum[ENTRY_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        link_count_next = link_count_reg;
        idx_next        = idx_reg;
        lidx_next       = lidx_reg;
        pass_next       = pass_reg;
        key_next        = key_reg;
        key_b_next      = key_b_reg;
        act_next        = act_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        adx_next        = adx_reg;
        ady_next        = ady_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        fa_next         = fa_reg;
        sq_next         = sq_reg;
        rad_next        = rad_reg;
        root_next       = root_reg;
        rem_next        = rem_reg;
        iter_next       = iter_reg;
        num_next        = num_reg;
        q_next          = q_reg;
        lq_next         = lq_reg;
        k_next          = k_reg;
        sat_next        = sat_reg;
        upd_next        = upd_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        val_next        = val_reg;
        ovalid_next     = ovalid_reg;
        ostatus_next    = ostatus_reg;
        oslot_next      = oslot_reg;
        ototal_next     = ototal_reg;
        oval_next       = oval_reg;
        node_we         = 1'b0;
        link_we         = 1'b0;
        stiff_we        = 1'b0;

        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    act_next    = s_axis_tdata[1:0];
                    key_next    = s_axis_tdata[33:2];
                    key_b_next  = s_axis_tdata[65:34];
                    row_next    = s_axis_tdata[69:66];
                    col_next    = s_axis_tdata[73:70];
                    adx_next    = dx[16] ? 16'(-dx) : dx[15:0];
                    ady_next    = dy[16] ? 16'(-dy) : dy[15:0];
                    idx_next    = '0;
                    lidx_next   = '0;
                    pass_next   = 1'b0;
                    status_next = ST_OK;
                    slot_next   = '0;
                    val_next    = '0;
                    case (s_axis_tdata[1:0])
                        ACT_ADD:     state_next = S_NRD;
                        ACT_CONNECT: state_next = S_NRD;
                        ACT_READ:    state_next = S_MRA;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_NRD:
            begin
                if (idx_reg == node_count_reg)
                begin
                    if (act_reg == ACT_ADD)
                    begin
                        if (node_count_reg == CNT_W'(NODES))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            node_we         = 1'b1;
                            slot_next       = node_count_reg[NODE_W-1:0];
                            node_count_next = node_count_reg + 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    else if (!pass_reg)
                    begin
                        fa_next   = 1'b0;
                        pass_next = 1'b1;
                        key_next  = key_b_reg;
                        idx_next  = '0;
                    end
                    else
                    begin
                        status_next = ST_UNKNOWN;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_NCMP;
                end
            end
            S_NCMP:
            begin
                if (node_rd_reg == key_reg)
                begin
                    if (act_reg == ACT_ADD)
                    begin
                        status_next = ST_DUP;
                        slot_next   = idx_reg[NODE_W-1:0];
                        state_next  = S_DONE;
                    end
                    else if (!pass_reg)
                    begin
                        fa_next    = 1'b1;
                        ia_next    = idx_reg[NODE_W-1:0];
                        pass_next  = 1'b1;
                        key_next   = key_b_reg;
                        idx_next   = '0;
                        state_next = S_NRD;
                    end
                    else
                    begin
                        ib_next = idx_reg[NODE_W-1:0];
                        if (!fa_reg)
                        begin
                            status_next = ST_UNKNOWN;
                            state_next  = S_DONE;
                        end
                        else if (ia_reg == idx_reg[NODE_W-1:0])
                        begin
                            status_next = ST_ZERO;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_LRD;
                        end
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_NRD;
                end
            end
            S_LRD:
            begin
                if (lidx_reg == link_count_reg)
                begin
                    if (link_count_reg == LC_W'(MAX_LINKS))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        link_we         = 1'b1;
                        link_count_next = link_count_reg + 1'b1;
                        state_next      = S_SQA;
                    end
                end
                else
                begin
                    state_next = S_LCMP;
                end
            end
            S_LCMP:
            begin
                if (link_rd_reg == {ia_reg, ib_reg})
                begin
                    status_next = ST_DUP;
                    state_next  = S_DONE;
                end
                else
                begin
                    lidx_next  = lidx_reg + 1'b1;
                    state_next = S_LRD;
                end
            end
            S_SQA:
            begin
                sq_next    = adx_reg * adx_reg;
                state_next = S_SQB;
            end
            S_SQB:
            begin
                rad_next   = {(RAD_W-61)'(0), 33'({1'b0, sq_reg} + 33'(ady_reg * ady_reg)), 28'b0};
                root_next  = '0;
                rem_next   = '0;
                iter_next  = ITER_W'(ROOT_W - 1);
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (sq_trial_rem >= sq_trial)
                begin
                    rem_next  = REM_W'(sq_trial_rem - sq_trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_trial_rem[REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    lq_next    = (root_next == '0) ? ROOT_W'(1) : root_next;
                    num_next   = {ae_reg, (FRAC_BITS + LEN_FRAC)'(0)};
                    q_next     = '0;
                    rem_next   = '0;
                    iter_next  = ITER_W'(NUM_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_t >= {2'b0, lq_reg})
                begin
                    rem_next = div_t - {2'b0, lq_reg};
                    q_next   = {q_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_t;
                    q_next   = {q_reg[NUM_W-2:0], 1'b0};
                end
                num_next  = {num_reg[NUM_W-2:0], 1'b0};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    if (q_next[NUM_W-1:ENTRY_W-1] != '0)
                    begin
                        k_next   = ENTRY_MAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        k_next   = q_next[ENTRY_W-1:0];
                        sat_next = 1'b0;
                    end
                    upd_next   = '0;
                    state_next = S_URD;
                end
            end
            S_URD:
            begin
                state_next = S_UWR;
            end
            S_UWR:
            begin
                stiff_we = 1'b1;
                if (upd_sum[ENTRY_W] != upd_sum[ENTRY_W-1])
                begin
                    sat_next = 1'b1;
                end
                upd_next = upd_reg + 1'b1;
                if (upd_reg == 2'd3)
                begin
                    status_next = sat_next ? ST_SAT : ST_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_URD;
                end
            end
            S_MRA:
            begin
                state_next = S_MRD;
            end
            S_MRD:
            begin
                if (row_reg < node_count_reg && col_reg < node_count_reg && vrd_reg)
                begin
                    val_next = stiff_rd_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = status_reg;
                    oslot_next   = slot_reg;
                    ototal_next  = node_count_reg;
                    oval_next    = val_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ae_reg         <= AE_RESET;
            node_count_reg <= '0;
            link_count_reg <= '0;
            ovalid_reg     <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            link_count_reg <= link_count_next;
            ovalid_reg     <= ovalid_next;
            if (cfg_we)
            begin
                ae_reg <= cfg_wdata;
            end
            if (stiff_we)
            begin
                valid_reg[stiff_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        lidx_reg    <= lidx_next;
        pass_reg    <= pass_next;
        key_reg     <= key_next;
        key_b_reg   <= key_b_next;
        act_reg     <= act_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        adx_reg     <= adx_next;
        ady_reg     <= ady_next;
        ia_reg      <= ia_next;
        ib_reg      <= ib_next;
        fa_reg      <= fa_next;
        sq_reg      <= sq_next;
        rad_reg     <= rad_next;
        root_reg    <= root_next;
        rem_reg     <= rem_next;
        iter_reg    <= iter_next;
        num_reg     <= num_next;
        q_reg       <= q_next;
        lq_reg      <= lq_next;
        k_reg       <= k_next;
        sat_reg     <= sat_next;
        upd_reg     <= upd_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        val_reg     <= val_next;
        ostatus_reg <= ostatus_next;
        oslot_reg   <= oslot_next;
        ototal_reg  <= ototal_next;
        oval_reg    <= oval_next;
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_count_reg[NODE_W-1:0]] <= key_reg;
        end
        node_rd_reg <= node_mem[idx_reg[NODE_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_count_reg[LI_W-1:0]] <= {ia_reg, ib_reg};
        end
        link_rd_reg <= link_mem[lidx_reg[LI_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (stiff_we)
        begin
            stiff_mem[stiff_addr] <= stiff_wdata;
        end
        stiff_rd_reg <= stiff_mem[stiff_addr];
        vrd_reg      <= valid_reg[stiff_addr];
    end

`ifndef NO_ASSERTIONS
    a_node_count: assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg <= CNT_W'(NODES))
        else $error("node count beyond table size");

    a_link_count: assert property (@(posedge clk) disable iff (!rst_n)
        link_count_reg <= LC_W'(MAX_LINKS))
        else $error("link count beyond table size");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (lq_reg != '0))
        else $error("divider started with zero length");

    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !ovalid_reg) |=> ovalid_reg)
        else $error("finished transaction not presented");
`endif

endmodule
